// ----- sv/pdq_pkg.sv -----
// pdq_pkg: shared types and codes for the positional deque store
// request and status codes, cell command type, default sizes
// no dependencies
package pdq_pkg;

   // fixed field widths of the request and response words
   localparam int REQ_WIDTH       = 3;
   localparam int POS_WIDTH       = 5;
   localparam int STATUS_WIDTH    = 2;
   localparam int COUNT_OUT_WIDTH = 5;

   // cell index width large enough for the deepest supported store
   localparam int MAX_INDEX_WIDTH = 8;

   // default sizes
   localparam int DEFAULT_DEPTH      = 16;
   localparam int DEFAULT_DATA_WIDTH = 32;

   // request codes
   localparam logic [REQ_WIDTH-1:0] REQ_ADD_BACK   = 3'd0;
   localparam logic [REQ_WIDTH-1:0] REQ_ADD_FRONT  = 3'd1;
   localparam logic [REQ_WIDTH-1:0] REQ_TAKE_BACK  = 3'd2;
   localparam logic [REQ_WIDTH-1:0] REQ_TAKE_FRONT = 3'd3;
   localparam logic [REQ_WIDTH-1:0] REQ_INSERT     = 3'd4;
   localparam logic [REQ_WIDTH-1:0] REQ_ERASE      = 3'd5;
   localparam logic [REQ_WIDTH-1:0] REQ_CLEAR      = 3'd6;

   // status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_BAD_IDX = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL    = 2'd3;

   // what the cell row does in one cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   // command broadcast to every cell
   typedef struct packed {
      cell_op_type                op;
      logic [MAX_INDEX_WIDTH-1:0] pos;
   } cell_cmd_type;

endpackage

// ----- sv/positional_deque_store_unit.sv -----
// positional_deque_store_unit: top level of the positional deque store
// a count register and control in front of a row of pdq_cell instances
// depends on pdq_pkg and pdq_cell
// the response word is registered and shown in the cycle after the request is accepted
// throughput: one request per cycle while busy is low, set by the one-step shift of the cell row
// reset: synchronous; clears the count and response strobe, busy is high during reset
// and the cycle after, cell contents are not cleared; the receiver cannot stall
module positional_deque_store_unit #(
   parameter int DEPTH      = pdq_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = pdq_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pdq_pkg::REQ_WIDTH-1:0]       req_type,
   input  logic [pdq_pkg::POS_WIDTH-1:0]       req_position,
   input  logic [DATA_WIDTH-1:0]               req_new_value,
   output logic                                rsp_valid,
   output logic [pdq_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic [pdq_pkg::COUNT_OUT_WIDTH-1:0] rsp_item_count,
   output logic [DATA_WIDTH-1:0]               rsp_front_value,
   output logic [DATA_WIDTH-1:0]               rsp_back_value
);
   import pdq_pkg::*;

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

   logic                    busy_ff;
   logic                    rsp_valid_ff;
   logic [STATUS_WIDTH-1:0] status_ff;
   logic [STATUS_WIDTH-1:0] status_in;
   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;

   logic                    accept;
   logic                    full;
   logic                    empty;
   logic [CMPW-1:0]         pos_ext;
   logic [CMPW-1:0]         cnt_ext;
   cell_cmd_type            cmd;
   cell_cmd_type            cell_cmd;

   logic [MAX_INDEX_WIDTH-1:0] back_index;
   logic [DATA_WIDTH-1:0]      cell_value  [DEPTH];
   logic [DATA_WIDTH-1:0]      left_value  [DEPTH];
   logic [DATA_WIDTH-1:0]      right_value [DEPTH];
   logic [DATA_WIDTH-1:0]      back_tap    [DEPTH];
   logic [DATA_WIDTH-1:0]      back_word;

   assign accept = start & ~busy_ff;
   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);

   // decode the request word into a cell command, new count and status
   always_comb begin
      pos_ext   = CMPW'(req_position);
      cnt_ext   = CMPW'(count_ff);
      cmd.op    = CELL_HOLD;
      cmd.pos   = '0;
      count_in  = count_ff;
      status_in = ST_OK;
      unique case (req_type)
         REQ_ADD_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.op   = CELL_INSERT;
               cmd.pos  = MAX_INDEX_WIDTH'(cnt_ext);
               count_in = count_ff + CW'(1);
            end
         end
         REQ_ADD_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.op   = CELL_INSERT;
               count_in = count_ff + CW'(1);
            end
         end
         REQ_TAKE_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         REQ_TAKE_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               cmd.op   = CELL_REMOVE;
               count_in = count_ff - CW'(1);
            end
         end
         REQ_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status_in = ST_BAD_IDX;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.op   = CELL_INSERT;
               cmd.pos  = MAX_INDEX_WIDTH'(pos_ext);
               count_in = count_ff + CW'(1);
            end
         end
         REQ_ERASE: begin
            if (pos_ext >= cnt_ext) begin
               status_in = ST_BAD_IDX;
            end else begin
               cmd.op   = CELL_REMOVE;
               cmd.pos  = MAX_INDEX_WIDTH'(pos_ext);
               count_in = count_ff - CW'(1);
            end
         end
         REQ_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // the row only moves on an accepted word
   always_comb begin
      cell_cmd = cmd;
      if (!accept) begin
         cell_cmd.op = CELL_HOLD;
      end
   end

   // count, status and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff  <= count_in;
            status_ff <= status_in;
         end
      end
   end

   // row of cells, front at cell zero
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_value[i] = cell_value[i];
      end else begin : g_inner_left
         assign left_value[i] = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_value[i] = cell_value[i];
      end else begin : g_inner_right
         assign right_value[i] = cell_value[i+1];
      end

      pdq_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .new_value   (req_new_value),
         .left_value  (left_value[i]),
         .right_value (right_value[i]),
         .back_index  (back_index),
         .cell_value  (cell_value[i]),
         .back_tap    (back_tap[i])
      );
   end

   // back word: one-hot taps from the cells merged
   assign back_index = MAX_INDEX_WIDTH'(count_ff - CW'(1));

   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_word = back_word | back_tap[i];
      end
   end

   // response word
   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_item_count  = COUNT_OUT_WIDTH'(count_ff);
   assign rsp_front_value = empty ? '0 : cell_value[0];
   assign rsp_back_value  = empty ? '0 : back_word;

endmodule

// ----- sv/pdq_cell.sv -----
// pdq_cell: one storage cell of the deque row
// shifts from its left or right neighbor, loads a new word, or holds
// depends on pdq_pkg
module pdq_cell #(
   parameter int DATA_WIDTH = pdq_pkg::DEFAULT_DATA_WIDTH,
   parameter int INDEX      = 0
) (
   input  logic                                clock,
   input  pdq_pkg::cell_cmd_type               cmd,
   input  logic [DATA_WIDTH-1:0]               new_value,
   input  logic [DATA_WIDTH-1:0]               left_value,
   input  logic [DATA_WIDTH-1:0]               right_value,
   input  logic [pdq_pkg::MAX_INDEX_WIDTH-1:0] back_index,
   output logic [DATA_WIDTH-1:0]               cell_value,
   output logic [DATA_WIDTH-1:0]               back_tap
);
   import pdq_pkg::*;

   localparam logic [MAX_INDEX_WIDTH-1:0] MY_INDEX = MAX_INDEX_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;

   // next value from the broadcast command and this cell's place
   always_comb begin
      value_in = value_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
            value_in = value_ff;
         end
         CELL_INSERT: begin
            if (MY_INDEX > cmd.pos) begin
               value_in = left_value;
            end else if (MY_INDEX == cmd.pos) begin
               value_in = new_value;
            end
         end
         CELL_REMOVE: begin
            if (MY_INDEX >= cmd.pos) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;

   // tap for the back word select
   assign back_tap = (back_index == MY_INDEX) ? value_ff : '0;

endmodule

// ----- sv/pdq_checker.sv -----
// pdq_checker: port-level assertions for positional_deque_store_unit
// bound to the top level at the end of this file
// depends on pdq_pkg
module pdq_checker #(
   parameter int DEPTH      = pdq_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = pdq_pkg::DEFAULT_DATA_WIDTH
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [pdq_pkg::STATUS_WIDTH-1:0]    rsp_status,
   input logic [pdq_pkg::COUNT_OUT_WIDTH-1:0] rsp_item_count,
   input logic                                rsp_valid,
   input logic [DATA_WIDTH-1:0]               rsp_front_value,
   input logic [DATA_WIDTH-1:0]               rsp_back_value
);
   import pdq_pkg::*;

   // every accepted word gives a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted word gave no response");

   // no response without an accepted word
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("response without accepted word");

   // an empty store shows zero front and back
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_count == '0) |->
         (rsp_front_value == '0 && rsp_back_value == '0))
      else $error("empty store shows nonzero front or back");

   // an empty error only comes from an empty store
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_item_count == '0))
      else $error("empty status with nonzero count");

   // a full flag only comes from a full store
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |->
         (rsp_item_count == COUNT_OUT_WIDTH'(DEPTH)))
      else $error("full status with store not full");

endmodule

bind positional_deque_store_unit pdq_checker #(
   .DEPTH      (DEPTH),
   .DATA_WIDTH (DATA_WIDTH)
) u_pdq_checker (.*);

// ----- verif/positional_deque_store_unit_tb.sv -----
`timescale 1ns / 1ps
// positional_deque_store_unit_tb: self-checking bench for the positional deque store
// drives request words through start/busy, predicts each response from a shadow deque
// depends on pdq_pkg and positional_deque_store_unit
module positional_deque_store_unit_tb;
   import pdq_pkg::*;

   localparam int STORE_DEPTH = DEFAULT_DEPTH;
   localparam int VALUE_WIDTH = DEFAULT_DATA_WIDTH;

   // the one request code the package leaves unnamed; the block ignores it
   localparam logic [REQ_WIDTH-1:0] REQ_UNUSED = 3'd7;

   // expected contents of one response word
   typedef struct {
      logic [STATUS_WIDTH-1:0]    status;
      logic [COUNT_OUT_WIDTH-1:0] count;
      logic [VALUE_WIDTH-1:0]     front;
      logic [VALUE_WIDTH-1:0]     back;
   } deque_view_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [REQ_WIDTH-1:0]       req_type;
   logic [POS_WIDTH-1:0]       req_position;
   logic [VALUE_WIDTH-1:0]     req_new_value;
   logic                       rsp_valid;
   logic [STATUS_WIDTH-1:0]    rsp_status;
   logic [COUNT_OUT_WIDTH-1:0] rsp_item_count;
   logic [VALUE_WIDTH-1:0]     rsp_front_value;
   logic [VALUE_WIDTH-1:0]     rsp_back_value;

   // shadow copy of the deque, front at cell 0
   logic [VALUE_WIDTH-1:0] shadow_cells [0:STORE_DEPTH-1];
   int unsigned            shadow_count = 0;

   deque_view_type pending_views [$];
   int             error_count = 0;

   positional_deque_store_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_new_value   (req_new_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_item_count  (rsp_item_count),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // safety net against a hung handshake
   initial begin
      #2_000_000;
      $display("positional_deque_store_unit_tb: errors");
      $finish;
   end

   // open a slot at index at and store v there
   function automatic logic [STATUS_WIDTH-1:0] shadow_put(input int unsigned at,
                                                          input logic [VALUE_WIDTH-1:0] v);
      int unsigned i;
      if (shadow_count >= STORE_DEPTH) begin
         return ST_FULL;
      end
      for (i = shadow_count; i > at; i--) begin
         shadow_cells[i] = shadow_cells[i-1];
      end
      shadow_cells[at] = v;
      shadow_count++;
      return ST_OK;
   endfunction

   // close the slot at index at
   function automatic logic [STATUS_WIDTH-1:0] shadow_take(input int unsigned at);
      int unsigned i;
      for (i = at; i + 1 < shadow_count; i++) begin
         shadow_cells[i] = shadow_cells[i+1];
      end
      shadow_count--;
      return ST_OK;
   endfunction

   // update the shadow deque for one accepted word and queue the expected response
   function automatic void apply_to_shadow(input logic [REQ_WIDTH-1:0] kind,
                                           input logic [POS_WIDTH-1:0] pos,
                                           input logic [VALUE_WIDTH-1:0] value);
      deque_view_type view;
      view.status = ST_OK;
      case (kind)
         REQ_ADD_BACK: begin
            view.status = shadow_put(shadow_count, value);
         end
         REQ_ADD_FRONT: begin
            view.status = shadow_put(0, value);
         end
         REQ_TAKE_BACK: begin
            if (shadow_count == 0) view.status = ST_EMPTY;
            else view.status = shadow_take(shadow_count - 1);
         end
         REQ_TAKE_FRONT: begin
            if (shadow_count == 0) view.status = ST_EMPTY;
            else view.status = shadow_take(0);
         end
         REQ_INSERT: begin
            // index check comes before the full check
            if (pos > shadow_count) view.status = ST_BAD_IDX;
            else view.status = shadow_put(32'(pos), value);
         end
         REQ_ERASE: begin
            if (pos >= shadow_count) view.status = ST_BAD_IDX;
            else view.status = shadow_take(32'(pos));
         end
         REQ_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      view.count = shadow_count[COUNT_OUT_WIDTH-1:0];
      if (shadow_count == 0) begin
         view.front = '0;
         view.back  = '0;
      end else begin
         view.front = shadow_cells[0];
         view.back  = shadow_cells[shadow_count-1];
      end
      pending_views.insert(pending_views.size(), view);
   endfunction

   // present one request word and hold it until the block takes it
   task automatic issue_request(input logic [REQ_WIDTH-1:0] kind,
                                input logic [POS_WIDTH-1:0] pos,
                                input logic [VALUE_WIDTH-1:0] value);
      @(negedge clock);
      start         <= 1'b1;
      req_type      <= kind;
      req_position  <= pos;
      req_new_value <= value;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      apply_to_shadow(kind, pos, value);
   endtask

   // drop start and leave the sender idle
   task automatic hold_off(input int unsigned cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // response checker
   always @(posedge clock) begin : check_rsp
      deque_view_type want;
      if (rsp_valid === 1'b1) begin
         if (pending_views.size() == 0) begin
            $error("response word with no request outstanding");
            error_count++;
         end else begin
            want = pending_views[0];
            pending_views.delete(0);
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_item_count !== want.count) begin
               $error("item_count: expected %0d, actual %0d", want.count, rsp_item_count);
               error_count++;
            end
            if (rsp_front_value !== want.front) begin
               $error("front_value: expected %h, actual %h", want.front, rsp_front_value);
               error_count++;
            end
            if (rsp_back_value !== want.back) begin
               $error("back_value: expected %h, actual %h", want.back, rsp_back_value);
               error_count++;
            end
         end
      end
   end

   // pops, erase and the ignored code on an empty store
   task automatic test_empty_errors;
      issue_request(REQ_TAKE_BACK, 5'd0, 32'h0);
      issue_request(REQ_TAKE_FRONT, 5'd0, 32'h0);
      issue_request(REQ_ERASE, 5'd0, 32'h0);
      issue_request(REQ_UNUSED, 5'd31, 32'hFFFF_FFFF);
   endtask

   // value extremes at both ends, insert and erase in range and out of range
   task automatic test_positions;
      issue_request(REQ_INSERT, 5'd1, 32'h1111_1111);
      issue_request(REQ_INSERT, 5'd0, 32'h0000_0000);
      issue_request(REQ_ADD_FRONT, 5'd0, 32'hFFFF_FFFF);
      issue_request(REQ_ADD_BACK, 5'd0, 32'h8000_0001);
      issue_request(REQ_INSERT, 5'd1, 32'hA5A5_A5A5);
      issue_request(REQ_ERASE, 5'd2, 32'h0);
      issue_request(REQ_ERASE, 5'd31, 32'h0);
      issue_request(REQ_INSERT, 5'd31, 32'h5A5A_5A5A);
   endtask

   // fill to capacity, push and insert when full, then pop each end and clear
   task automatic test_full_store;
      bit at_back;
      at_back = 1'b1;
      while (shadow_count < STORE_DEPTH) begin
         issue_request(at_back ? REQ_ADD_BACK : REQ_ADD_FRONT, 5'd0, $urandom);
         at_back = ~at_back;
      end
      issue_request(REQ_ADD_BACK, 5'd0, 32'hDEAD_0001);
      issue_request(REQ_INSERT, 5'd0, 32'hDEAD_0002);
      issue_request(REQ_INSERT, 5'd17, 32'hDEAD_0003);
      issue_request(REQ_TAKE_BACK, 5'd0, 32'h0);
      issue_request(REQ_TAKE_FRONT, 5'd0, 32'h0);
      issue_request(REQ_CLEAR, 5'd0, 32'h0);
   endtask

   // random words, grow or shrink bias changing every few dozen words
   task automatic test_random_mix(input int unsigned words, input int unsigned idle_pct);
      int unsigned            n;
      int unsigned            grow_pct;
      int unsigned            pick;
      logic [REQ_WIDTH-1:0]   kind;
      logic [POS_WIDTH-1:0]   pos;
      logic [VALUE_WIDTH-1:0] value;
      grow_pct = 50;
      for (n = 0; n < words; n++) begin
         // new bias: fill, drain or balanced
         if (n % 32 == 0) begin
            case ($urandom_range(0, 2))
               0: grow_pct = 80;
               1: grow_pct = 25;
               default: grow_pct = 50;
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 1) kind = REQ_UNUSED;
         else if (pick < 2) kind = REQ_CLEAR;
         else if ($urandom_range(0, 99) < grow_pct) begin
            case ($urandom_range(0, 2))
               0: kind = REQ_ADD_BACK;
               1: kind = REQ_ADD_FRONT;
               default: kind = REQ_INSERT;
            endcase
         end else begin
            case ($urandom_range(0, 2))
               0: kind = REQ_TAKE_BACK;
               1: kind = REQ_TAKE_FRONT;
               default: kind = REQ_ERASE;
            endcase
         end
         // mostly legal indexes, some anywhere in the field
         pos = POS_WIDTH'($urandom_range(0, 31));
         if ($urandom_range(0, 99) < 85) begin
            if (kind == REQ_INSERT) pos = POS_WIDTH'($urandom_range(0, shadow_count));
            else if (kind == REQ_ERASE && shadow_count > 0)
               pos = POS_WIDTH'($urandom_range(0, shadow_count - 1));
         end
         case ($urandom_range(0, 9))
            0: value = '0;
            1: value = '1;
            default: value = VALUE_WIDTH'($urandom);
         endcase
         // sender idles in about idle_pct cycles of a hundred
         while ($urandom_range(0, 99) < idle_pct) hold_off(1);
         issue_request(kind, pos, value);
      end
   endtask

   // test sequence
   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_type      = '0;
      req_position  = '0;
      req_new_value = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_errors;
      test_positions;
      test_full_store;
      test_random_mix(383, 7);
      test_random_mix(383, 67);
      test_random_mix(384, 0);

      // let the last response words drain
      @(negedge clock);
      start <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (error_count == 0) begin
         $display("positional_deque_store_unit_tb: clean");
      end else begin
         $display("positional_deque_store_unit_tb: errors");
      end
      $finish;
   end

endmodule
